// File: rtl/core/ecbf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ecbf_pkg;
    localparam int FrameWidth  = 128;
    localparam int FrameHeight = 128;
    localparam int StackDepth  = 4096;
    localparam int XW = $clog2(FrameWidth);
    localparam int YW = $clog2(FrameHeight);
    localparam int AW = XW + YW;
    localparam int SW = $clog2(StackDepth);
    localparam int CW = 24;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_FILL  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DONE    = 2'd1;
    localparam logic [1:0] ST_OUTSIDE = 2'd2;
    localparam logic [1:0] ST_OVF     = 2'd3;

    localparam logic [0:0] REG_BOUNDARY = 1'b0;
    localparam logic [0:0] REG_FILL     = 1'b1;

    typedef struct packed {
        logic         we;
        logic [AW-1:0] waddr;
        logic [CW-1:0] wdata;
        logic [AW-1:0] raddr;
    } fs_req_t;
endpackage
`default_nettype wire

// File: rtl/core/ecbf_frame_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module ecbf_frame_ram (
    input  wire logic              clk,
    input  wire ecbf_pkg::fs_req_t req,
    output logic [23:0]            rdata
);
    import ecbf_pkg::*;
    logic [CW-1:0] mem [0:(1<<AW)-1];
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end
endmodule
`default_nettype wire

// File: rtl/core/ecbf_stack_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module ecbf_stack_ram (
    input  wire logic        clk,
    input  wire logic        we,
    input  wire logic [11:0] waddr,
    input  wire logic [13:0] wdata,
    input  wire logic [11:0] raddr,
    output logic [13:0]      rdata
);
    import ecbf_pkg::*;
    logic [AW-1:0] mem [0:StackDepth-1];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: rtl/core/eight_connected_boundary_fill_core.sv
`timescale 1ns / 1ps
`default_nettype none
// 128x128 frame of 24-bit pixels with a stack-based 8-connected boundary fill.
// A write word goes from idle straight to the result state; a read word passes through
// a read and a read-wait state before the result is offered (single sequencer, registered
// frame memory read). A fill walks each seed direction one pixel at a time (walk, walk
// wait), then pops each coordinate (pop, pop wait, pixel) and probes its neighbors
// (neighbor, neighbor wait; a neighbor off the frame skips the wait), and finishes on a
// pop of the empty stack, all through the one frame memory port; stall on in stays high
// meanwhile. Stall on out holds the result. Memories need no clearing pass after reset.
module eight_connected_boundary_fill_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  opcode,
    input  wire logic [6:0]  x_pos,
    input  wire logic [6:0]  y_pos,
    input  wire logic [23:0] pixel_color,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [23:0]      read_color,
    output logic [1:0]       status
);
    import ecbf_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_RD    = 11'b00000000010,
        S_RDW   = 11'b00000000100,
        S_WALK  = 11'b00000001000,
        S_WALKW = 11'b00000010000,
        S_POP   = 11'b00000100000,
        S_POPW  = 11'b00001000000,
        S_PIX   = 11'b00010000000,
        S_NB    = 11'b00100000000,
        S_NBW   = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] bcol_reg, fcol_reg;
    logic [XW-1:0] x_reg, cx_reg;
    logic [YW-1:0] y_reg, cy_reg;
    logic [1:0] dir_reg;
    logic [2:0] nb_reg;
    logic [SW:0] sp_reg;
    logic ovf_reg;
    logic [CW-1:0] rc_reg;
    logic [1:0] st_reg;

    fs_req_t fs_req;
    logic [CW-1:0] fs_rdata;
    logic sk_we;
    logic [SW-1:0] sk_waddr, sk_raddr;
    logic [AW-1:0] sk_wdata, sk_rdata;

    ecbf_frame_ram u_frame (.clk(clk), .req(fs_req), .rdata(fs_rdata));
    ecbf_stack_ram u_stack (.clk(clk), .we(sk_we), .waddr(sk_waddr), .wdata(sk_wdata),
        .raddr(sk_raddr), .rdata(sk_rdata));

    logic is_stop;
    assign is_stop = (fs_rdata == bcol_reg) || (fs_rdata == fcol_reg);

    // walk step
    logic [XW:0] wx;
    logic [YW:0] wy;
    logic w_in;
    always_comb
    begin
        wx = {1'b0, cx_reg};
        wy = {1'b0, cy_reg};
        case (dir_reg)
            2'd0: wx = {1'b0, cx_reg} - 1'b1;
            2'd1: wy = {1'b0, cy_reg} + 1'b1;
            2'd2: wx = {1'b0, cx_reg} + 1'b1;
            default: wy = {1'b0, cy_reg} - 1'b1;
        endcase
        w_in = !wx[XW] && !wy[YW];
    end

    // neighbor offset
    logic [XW:0] nx;
    logic [YW:0] ny;
    logic n_in;
    always_comb
    begin
        nx = {1'b0, x_reg};
        ny = {1'b0, y_reg};
        case (nb_reg)
            3'd0: nx = {1'b0, x_reg} - 1'b1;
            3'd1: begin nx = {1'b0, x_reg} - 1'b1; ny = {1'b0, y_reg} + 1'b1; end
            3'd2: ny = {1'b0, y_reg} + 1'b1;
            3'd3: begin nx = {1'b0, x_reg} + 1'b1; ny = {1'b0, y_reg} + 1'b1; end
            3'd4: nx = {1'b0, x_reg} + 1'b1;
            3'd5: begin nx = {1'b0, x_reg} + 1'b1; ny = {1'b0, y_reg} - 1'b1; end
            3'd6: ny = {1'b0, y_reg} - 1'b1;
            default: begin nx = {1'b0, x_reg} - 1'b1; ny = {1'b0, y_reg} - 1'b1; end
        endcase
        n_in = !nx[XW] && !ny[YW];
    end

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign read_color = rc_reg;
    assign status = st_reg;

    logic accept;
    assign accept = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        fs_req.we = 1'b0;
        fs_req.waddr = {y_reg, x_reg};
        fs_req.wdata = fcol_reg;
        fs_req.raddr = {y_reg, x_reg};
        sk_we = 1'b0;
        sk_waddr = sp_reg[SW-1:0];
        sk_wdata = {ny[YW-1:0], nx[XW-1:0]};
        sk_raddr = sp_reg[SW-1:0] - 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_WRITE)
                    begin
                        fs_req.we = 1'b1;
                        fs_req.waddr = {y_pos, x_pos};
                        fs_req.wdata = pixel_color;
                        state_next = S_OUT;
                    end
                    else if (opcode == OP_READ)
                    begin
                        state_next = S_RD;
                    end
                    else if (opcode == OP_FILL)
                    begin
                        state_next = S_WALK;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_RD:    state_next = S_RDW;
            S_RDW:   state_next = S_OUT;
            S_WALK:
            begin
                fs_req.raddr = {wy[YW-1:0], wx[XW-1:0]};
                state_next = w_in ? S_WALKW : S_OUT;
            end
            S_WALKW:
            begin
                if (is_stop)
                begin
                    if (dir_reg == 2'd3)
                    begin
                        sk_we = 1'b1;
                        sk_waddr = '0;
                        sk_wdata = {y_reg, x_reg};
                        state_next = S_POP;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_POP:
            begin
                state_next = (sp_reg == '0) ? S_OUT : S_POPW;
            end
            S_POPW:
            begin
                fs_req.raddr = sk_rdata;
                state_next = S_PIX;
            end
            S_PIX:
            begin
                if (fs_rdata == fcol_reg)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    fs_req.we = 1'b1;
                    state_next = S_NB;
                end
            end
            S_NB:
            begin
                fs_req.raddr = {ny[YW-1:0], nx[XW-1:0]};
                if (n_in)
                begin
                    state_next = S_NBW;
                end
                else
                begin
                    state_next = (nb_reg == 3'd7) ? S_POP : S_NB;
                end
            end
            S_NBW:
            begin
                if (!is_stop && (sp_reg != StackDepth[SW:0]))
                begin
                    sk_we = 1'b1;
                end
                state_next = (nb_reg == 3'd7) ? S_POP : S_NB;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            bcol_reg <= '0;
            fcol_reg <= 24'hFF0000;
            sp_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_BOUNDARY: bcol_reg <= cfg_data;
                    REG_FILL:     fcol_reg <= cfg_data;
                    default:      ;
                endcase
            end
            if (state_reg == S_WALKW && is_stop && dir_reg == 2'd3)
            begin
                sp_reg <= {{SW{1'b0}}, 1'b1};
            end
            else if (state_reg == S_POP && sp_reg != '0)
            begin
                sp_reg <= sp_reg - 1'b1;
            end
            else if (sk_we)
            begin
                sp_reg <= sp_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                x_reg <= x_pos;
                y_reg <= y_pos;
                cx_reg <= x_pos;
                cy_reg <= y_pos;
                dir_reg <= 2'd0;
                ovf_reg <= 1'b0;
                rc_reg <= '0;
                st_reg <= (opcode == OP_FILL) ? ST_DONE : ST_OK;
            end
            S_RDW:
            begin
                rc_reg <= fs_rdata;
            end
            S_WALK:
            begin
                if (!w_in)
                begin
                    st_reg <= ST_OUTSIDE;
                end
                cx_reg <= wx[XW-1:0];
                cy_reg <= wy[YW-1:0];
            end
            S_WALKW:
            begin
                if (is_stop)
                begin
                    dir_reg <= dir_reg + 1'b1;
                    cx_reg <= x_reg;
                    cy_reg <= y_reg;
                end
            end
            S_POP:
            begin
                if (sp_reg == '0)
                begin
                    st_reg <= ovf_reg ? ST_OVF : ST_DONE;
                end
            end
            S_POPW:
            begin
                x_reg <= sk_rdata[XW-1:0];
                y_reg <= sk_rdata[AW-1:XW];
                nb_reg <= 3'd0;
            end
            S_NB:
            begin
                if (!n_in)
                begin
                    nb_reg <= nb_reg + 1'b1;
                end
            end
            S_NBW:
            begin
                if (!is_stop && (sp_reg == StackDepth[SW:0]))
                begin
                    ovf_reg <= 1'b1;
                end
                nb_reg <= nb_reg + 1'b1;
            end
            default: ;
        endcase
    end

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");
    a_sp: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= StackDepth[SW:0])
        else $error("stack pointer beyond depth");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(read_color)))
        else $error("result dropped");
endmodule
`default_nettype wire

// File: bench/fill_checker.sv
`timescale 1ns / 1ps
module fill_checker
    import ecbf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [1:0]  opcode,
    input  wire logic [6:0]  x_pos,
    input  wire logic [6:0]  y_pos,
    input  wire logic [23:0] pixel_color,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [23:0] read_color,
    input  wire logic [1:0]  status,
    output int               errors,
    output int               pending
);
    typedef struct packed {
        logic [CW-1:0] color;
        logic [1:0]    st;
    } answer_t;

    logic [CW-1:0] picture [0:FrameWidth*FrameHeight-1];
    int            coords [0:StackDepth-1];
    logic [CW-1:0] border;
    logic [CW-1:0] paint;
    answer_t       answers [$];

    localparam int NDX [8] = '{-1, -1, 0, 1, 1, 1, 0, -1};
    localparam int NDY [8] = '{0, 1, 1, 1, 0, -1, -1, -1};
    localparam int WDX [4] = '{-1, 0, 1, 0};
    localparam int WDY [4] = '{0, 1, 0, -1};

    function automatic bit on_frame(int x, int y);
        return x >= 0 && x < FrameWidth && y >= 0 && y < FrameHeight;
    endfunction

    function automatic bit is_wall(int x, int y);
        logic [CW-1:0] c;
        if (!on_frame(x, y))
            return 1'b1;
        c = picture[y*FrameWidth+x];
        return c == border || c == paint;
    endfunction

    function automatic logic [1:0] flood(int sx, int sy);
        int  depth;
        int  x;
        int  y;
        int  code;
        bit  hit;
        bit  spill;
        depth = 0;
        spill = 1'b0;
        for (int d = 0; d < 4; d++)
        begin
            x = sx + WDX[d];
            y = sy + WDY[d];
            hit = 1'b0;
            while (on_frame(x, y) && !hit)
            begin
                if (is_wall(x, y))
                    hit = 1'b1;
                x += WDX[d];
                y += WDY[d];
            end
            if (!hit)
                return ST_OUTSIDE;
        end
        coords[0] = sy*FrameWidth + sx;
        depth = 1;
        while (depth > 0)
        begin
            depth--;
            code = coords[depth];
            x = code % FrameWidth;
            y = code / FrameWidth;
            if (picture[code] != paint)
            begin
                picture[code] = paint;
                for (int n = 0; n < 8; n++)
                begin
                    if (!is_wall(x + NDX[n], y + NDY[n]))
                    begin
                        if (depth >= StackDepth)
                            spill = 1'b1;
                        else
                        begin
                            coords[depth] = (y + NDY[n])*FrameWidth + x + NDX[n];
                            depth++;
                        end
                    end
                end
            end
        end
        return spill ? ST_OVF : ST_DONE;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t a;
        answer_t e;
        int      bad;
        if (!rst_n)
        begin
            border  <= '0;
            paint   <= 24'hFF0000;
            answers.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            bad = 0;
            if (out_valid && !out_stall)
            begin
                if (answers.size() == 0)
                begin
                    $error("unexpected word: read_color %h status %0d", read_color, status);
                    bad++;
                end
                else
                begin
                    e = answers.pop_front();
                    if (read_color !== e.color)
                    begin
                        $error("read_color: expected %h, got %h", e.color, read_color);
                        bad++;
                    end
                    if (status !== e.st)
                    begin
                        $error("status: expected %0d, got %0d", e.st, status);
                        bad++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                a = '0;
                case (opcode)
                    OP_WRITE: picture[{y_pos, x_pos}] = pixel_color;
                    OP_READ:  a.color = picture[{y_pos, x_pos}];
                    OP_FILL:  a.st = flood(x_pos, y_pos);
                    default:  a = '0;
                endcase
                answers.push_back(a);
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_BOUNDARY)
                    border <= cfg_data;
                else
                    paint <= cfg_data;
            end
            errors  <= errors + bad;
            pending <= answers.size();
        end
    end
endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import ecbf_pkg::*;

    localparam int BoxLo = 48;
    localparam int BoxHi = 63;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [23:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  opcode;
    logic [6:0]  x_pos;
    logic [6:0]  y_pos;
    logic [23:0] pixel_color;
    logic        out_valid;
    logic        out_stall;
    logic [23:0] read_color;
    logic [1:0]  status;
    int          errors;
    int          pending;
    bit          calm;
    int          hold;
    int          sent;
    logic [23:0] wall_col;
    logic [23:0] paint_col;

    eight_connected_boundary_fill_core DUT (.*);

    fill_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold      <= 0;
        end
        else if (calm)
        begin
            out_stall <= 1'b0;
            hold      <= 0;
        end
        else if (hold > 0)
            hold <= hold - 1;
        else if ($urandom_range(0, 9) == 0)
        begin
            out_stall <= 1'b1;
            hold      <= $urandom_range(0, 14);
        end
        else
            out_stall <= 1'b0;
    end

    function automatic logic [23:0] any_color();
        logic [31:0] r;
        r = $urandom;
        return r[23:0];
    endfunction

    task automatic set_reg(logic [0:0] idx, logic [23:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic send(logic [1:0] op, int x, int y, logic [23:0] c);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        x_pos       <= x[6:0];
        y_pos       <= y[6:0];
        pixel_color <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
    endtask

    // closed ring in the boundary color around the work area
    task automatic ring(logic [23:0] c);
        for (int i = BoxLo; i <= BoxHi; i++)
        begin
            send(OP_WRITE, i, BoxLo, c);
            send(OP_WRITE, i, BoxHi, c);
        end
        for (int i = BoxLo + 1; i < BoxHi; i++)
        begin
            send(OP_WRITE, BoxLo, i, c);
            send(OP_WRITE, BoxHi, i, c);
        end
    endtask

    task automatic load_inside();
        for (int y = BoxLo + 1; y < BoxHi; y++)
            for (int x = BoxLo + 1; x < BoxHi; x++)
            begin
                if ($urandom_range(0, 5) == 0)
                    send(OP_WRITE, x, y, wall_col);
                else
                    send(OP_WRITE, x, y, any_color());
            end
    endtask

    task automatic random_phase(int count);
        int          last;
        logic [23:0] c;
        last = sent + count;
        while (sent < last)
        begin
            case ($urandom_range(0, 9))
                0, 1:    send(OP_FILL, $urandom_range(BoxLo + 1, BoxHi - 1),
                              $urandom_range(BoxLo + 1, BoxHi - 1), any_color());
                2, 3, 4:
                begin
                    case ($urandom_range(0, 7))
                        0:       c = wall_col;
                        1:       c = paint_col;
                        default: c = any_color();
                    endcase
                    send(OP_WRITE, $urandom_range(BoxLo + 1, BoxHi - 1),
                         $urandom_range(BoxLo + 1, BoxHi - 1), c);
                end
                5, 6, 7: send(OP_READ, $urandom_range(BoxLo, BoxHi),
                              $urandom_range(BoxLo, BoxHi), any_color());
                8:       send(OP_FILL, 0, $urandom_range(0, 127), any_color());
                default: send(2'd3, $urandom_range(0, 127), $urandom_range(0, 127),
                              any_color());
            endcase
        end
        settle();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        opcode      = '0;
        x_pos       = '0;
        y_pos       = '0;
        pixel_color = '0;
        calm        = 1'b0;
        sent        = 0;
        wall_col    = 24'h000000;
        paint_col   = 24'hFF0000;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_reg(REG_BOUNDARY, wall_col);
        set_reg(REG_FILL, paint_col);
        ring(wall_col);
        load_inside();

        send(OP_WRITE, 0, 20, 24'h000077);
        send(OP_WRITE, 1, 20, 24'h000077);
        send(OP_READ, 0, 20, 24'hFFFFFF);
        send(2'd3, 127, 127, 24'hFFFFFF);
        // open row reaching the left edge: refused
        send(OP_FILL, 2, 20, 24'h0);
        send(OP_FILL, 0, 64, 24'h0);
        send(OP_WRITE, 50, 50, paint_col);
        send(OP_FILL, 50, 50, 24'h0);
        send(OP_READ, 50, 50, 24'h0);
        send(OP_FILL, 55, 55, 24'h0);
        send(OP_READ, 55, 55, 24'h0);
        send(OP_READ, BoxLo, BoxLo, 24'h0);
        settle();

        random_phase(140);

        wall_col  = 24'hFFFFFF;
        paint_col = 24'h000000;
        set_reg(REG_BOUNDARY, wall_col);
        set_reg(REG_FILL, paint_col);
        ring(wall_col);
        random_phase(140);

        wall_col  = 24'h000000;
        paint_col = 24'($urandom_range(1, 24'hFFFFFE));
        set_reg(REG_BOUNDARY, wall_col);
        set_reg(REG_FILL, paint_col);
        ring(wall_col);
        random_phase(140);

        wall_col  = 24'($urandom_range(1, 24'hFFFFFE));
        paint_col = 24'h000000;
        set_reg(REG_FILL, paint_col);
        set_reg(REG_BOUNDARY, wall_col);
        ring(wall_col);
        random_phase(140);

        wall_col  = 24'h000000;
        paint_col = 24'hFFFFFF;
        set_reg(REG_BOUNDARY, wall_col);
        set_reg(REG_FILL, paint_col);
        calm = 1'b1;
        ring(wall_col);
        random_phase(140);

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
